>>> src/least_loaded_node_dispatcher_defines.svh
// assertion macros used by the dispatcher core
`ifndef LEAST_LOADED_NODE_DISPATCHER_DEFINES_SVH
`define LEAST_LOADED_NODE_DISPATCHER_DEFINES_SVH

// condition holds at every clock edge out of reset
`define LLD_ASSERT_ALWAYS(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

// consequent holds in the same cycle as the antecedent
`define LLD_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define LLD_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/lld_pkg.sv
// types and constants of the least-loaded node dispatcher
`timescale 1ns / 1ps
`default_nettype none

package lld_pkg;

   // default table sizes
   localparam int NODE_SLOTS_DEF     = 32;
   localparam int WORKLOAD_SLOTS_DEF = 64;

   // field widths
   localparam int OP_W       = 2;
   localparam int TARGET_W   = 6;
   localparam int REPLICA_W  = 8;
   localparam int ASSIGNED_W = 7;
   localparam int RUNNING_W  = 8;
   localparam int PLACED_W   = 6;
   localparam int LEADER_W   = 6;
   localparam int EPOCH_W    = 32;

   // node load counter
   localparam int               LOAD_W   = 14;
   localparam logic [LOAD_W-1:0] LOAD_MAX = '1;

   localparam logic [EPOCH_W-1:0] EPOCH_RESET = 32'd1;

   // operation codes
   typedef enum logic [OP_W-1:0] {
      OP_REGISTER = 2'd0,
      OP_READY    = 2'd1,
      OP_SCHEDULE = 2'd2,
      OP_ELECT    = 2'd3
   } op_type;

   typedef struct packed {
      logic [OP_W-1:0]      op;
      logic [TARGET_W-1:0]  target_node;
      logic [REPLICA_W-1:0] replica_count;
   } lld_req_type;

   typedef struct packed {
      logic                  status;
      logic [ASSIGNED_W-1:0] assigned_id;
      logic [RUNNING_W-1:0]  running_count;
      logic [PLACED_W-1:0]   placed_node;
      logic [LEADER_W-1:0]   leader_node;
      logic [EPOCH_W-1:0]    epoch_value;
   } lld_rsp_type;

   // top to core: start a request, take the finished result
   typedef struct packed {
      logic start;
      logic ack;
   } lld_ctl_type;

   // core to top
   typedef struct packed {
      logic idle;
      logic done;
   } lld_stat_type;

endpackage

`default_nettype wire

>>> src/lld_req_if.sv
// request channel of the dispatcher
`timescale 1ns / 1ps
`default_nettype none

interface lld_req_if;
   import lld_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [OP_W-1:0]      op;
   logic [TARGET_W-1:0]  target_node;
   logic [REPLICA_W-1:0] replica_count;

   modport source (output valid, output op, output target_node, output replica_count,
                   input ready);
   modport sink (input valid, input op, input target_node, input replica_count,
                 output ready);
endinterface

`default_nettype wire

>>> src/lld_rsp_if.sv
// response channel of the dispatcher
`timescale 1ns / 1ps
`default_nettype none

interface lld_rsp_if;
   import lld_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  status;
   logic [ASSIGNED_W-1:0] assigned_id;
   logic [RUNNING_W-1:0]  running_count;
   logic [PLACED_W-1:0]   placed_node;
   logic [LEADER_W-1:0]   leader_node;
   logic [EPOCH_W-1:0]    epoch_value;

   modport source (output valid, output status, output assigned_id, output running_count,
                   output placed_node, output leader_node, output epoch_value,
                   input ready);
   modport sink (input valid, input status, input assigned_id, input running_count,
                 input placed_node, input leader_node, input epoch_value,
                 output ready);
endinterface

`default_nettype wire

>>> src/lld_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module lld_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

>>> src/lld_core.sv
// dispatcher engine: node table in ram, sequencer for register, ready, schedule, elect
`timescale 1ns / 1ps
`default_nettype none
`include "least_loaded_node_dispatcher_defines.svh"

module lld_core #(
   parameter int NODE_SLOTS     = lld_pkg::NODE_SLOTS_DEF,
   parameter int WORKLOAD_SLOTS = lld_pkg::WORKLOAD_SLOTS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire lld_pkg::lld_ctl_type  ctl,
   input  wire lld_pkg::lld_req_type  req,
   output lld_pkg::lld_stat_type      stat,
   output lld_pkg::lld_rsp_type       rsp
);
   import lld_pkg::*;

   localparam int IDX_W   = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
   localparam int CNT_W   = $clog2(NODE_SLOTS + 1);
   localparam int WL_W    = $clog2(WORKLOAD_SLOTS + 1);
   localparam int CMP_W   = (CNT_W > TARGET_W) ? CNT_W : TARGET_W;
   localparam int ENTRY_W = LOAD_W + 1;
   localparam logic [CNT_W-1:0] NODE_MAX = CNT_W'(NODE_SLOTS);
   localparam logic [WL_W-1:0]  WL_MAX   = WL_W'(WORKLOAD_SLOTS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MARK_RD,
      S_MARK_WR,
      S_SCAN,
      S_UPDATE,
      S_RESULT
   } state_type;

   // control state
   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      node_total_ff, node_total_in;
   logic [WL_W-1:0]       workload_total_ff, workload_total_in;
   logic                  leader_ff, leader_in;
   logic [EPOCH_W-1:0]    epoch_ff, epoch_in;
   logic [REPLICA_W-1:0]  rep_left_ff, rep_left_in;
   logic [CNT_W-1:0]      issue_ff, issue_in;
   logic                  pend_ff, pend_in;
   logic                  found_ff, found_in;

   // payload
   logic [IDX_W-1:0]      pend_idx_ff, pend_idx_in;
   logic [IDX_W-1:0]      best_idx_ff, best_idx_in;
   logic [LOAD_W-1:0]     best_load_ff, best_load_in;
   logic [IDX_W-1:0]      tgt_idx_ff, tgt_idx_in;
   logic                  status_ff, status_in;
   logic [ASSIGNED_W-1:0] assigned_ff, assigned_in;
   logic [RUNNING_W-1:0]  running_ff, running_in;
   logic [PLACED_W-1:0]   placed_ff, placed_in;

   // node table port
   logic                  ram_we;
   logic [IDX_W-1:0]      ram_waddr;
   logic [ENTRY_W-1:0]    ram_wdata;
   logic [IDX_W-1:0]      ram_raddr;
   logic [ENTRY_W-1:0]    ram_rdata;
   logic                  rd_ready;
   logic [LOAD_W-1:0]     rd_load;
   logic                  tgt_bad;

   // entry is {ready, load}
   lld_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NODE_SLOTS)
   ) u_node_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rd_ready = ram_rdata[LOAD_W];
   assign rd_load  = ram_rdata[LOAD_W-1:0];
   assign tgt_bad  = (req.target_node == '0) ||
                     (CMP_W'(req.target_node) > CMP_W'(node_total_ff));

   // sequencer next state
   always_comb begin
      state_in          = state_ff;
      node_total_in     = node_total_ff;
      workload_total_in = workload_total_ff;
      leader_in         = leader_ff;
      epoch_in          = epoch_ff;
      rep_left_in       = rep_left_ff;
      issue_in          = issue_ff;
      pend_in           = pend_ff;
      found_in          = found_ff;
      pend_idx_in       = pend_idx_ff;
      best_idx_in       = best_idx_ff;
      best_load_in      = best_load_ff;
      tgt_idx_in        = tgt_idx_ff;
      status_in         = status_ff;
      assigned_in       = assigned_ff;
      running_in        = running_ff;
      placed_in         = placed_ff;
      ram_we            = 1'b0;
      ram_waddr         = '0;
      ram_wdata         = '0;
      ram_raddr         = issue_ff[IDX_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (ctl.start) begin
               status_in   = 1'b0;
               assigned_in = '0;
               running_in  = '0;
               placed_in   = '0;
               state_in    = S_RESULT;
               unique case (op_type'(req.op))
                  OP_REGISTER: begin
                     if (node_total_ff == NODE_MAX) begin
                        status_in = 1'b1;
                     end else begin
                        // new node joins not ready with zero load
                        ram_we        = 1'b1;
                        ram_waddr     = node_total_ff[IDX_W-1:0];
                        ram_wdata     = '0;
                        if (node_total_ff == '0) begin
                           leader_in = 1'b1;
                        end
                        node_total_in = node_total_ff + 1'b1;
                        assigned_in   = ASSIGNED_W'(node_total_ff) + 1'b1;
                     end
                  end
                  OP_READY: begin
                     if (tgt_bad) begin
                        status_in = 1'b1;
                     end else begin
                        tgt_idx_in = IDX_W'(req.target_node - 1'b1);
                        state_in   = S_MARK_RD;
                     end
                  end
                  OP_SCHEDULE: begin
                     if (workload_total_ff == WL_MAX) begin
                        status_in = 1'b1;
                     end else begin
                        workload_total_in = workload_total_ff + 1'b1;
                        assigned_in       = ASSIGNED_W'(workload_total_ff + 1'b1);
                        rep_left_in       = req.replica_count;
                        issue_in          = '0;
                        pend_in           = 1'b0;
                        found_in          = 1'b0;
                        if (req.replica_count != '0) begin
                           state_in = S_SCAN;
                        end
                     end
                  end
                  OP_ELECT: begin
                     leader_in = (node_total_ff != '0);
                     epoch_in  = epoch_ff + 1'b1;
                  end
                  default: begin
                     status_in = 1'b1;
                  end
               endcase
            end
         end

         // mark ready: read entry, write back with ready set
         S_MARK_RD: begin
            ram_raddr = tgt_idx_ff;
            state_in  = S_MARK_WR;
         end

         S_MARK_WR: begin
            ram_we    = 1'b1;
            ram_waddr = tgt_idx_ff;
            ram_wdata = {1'b1, rd_load};
            state_in  = S_RESULT;
         end

         // stream the table out, one read per cycle, keep first strict minimum
         S_SCAN: begin
            if (pend_ff && rd_ready && (!found_ff || (rd_load < best_load_ff))) begin
               found_in     = 1'b1;
               best_load_in = rd_load;
               best_idx_in  = pend_idx_ff;
            end
            if (issue_ff != node_total_ff) begin
               ram_raddr   = issue_ff[IDX_W-1:0];
               issue_in    = issue_ff + 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = issue_ff[IDX_W-1:0];
            end else begin
               pend_in  = 1'b0;
               state_in = S_UPDATE;
            end
         end

         // place one replica on the chosen node if one was found, saturating the load
         S_UPDATE: begin
            if (found_ff) begin
               ram_we     = 1'b1;
               ram_waddr  = best_idx_ff;
               ram_wdata  = {1'b1, (best_load_ff == LOAD_MAX) ? best_load_ff
                                                              : best_load_ff + 1'b1};
               running_in = running_ff + 1'b1;
               placed_in  = PLACED_W'({1'b0, best_idx_ff} + 1'b1);
            end
            rep_left_in = rep_left_ff - 1'b1;
            issue_in    = '0;
            pend_in     = 1'b0;
            found_in    = 1'b0;
            if (rep_left_ff == REPLICA_W'(1)) begin
               state_in = S_RESULT;
            end else begin
               state_in = S_SCAN;
            end
         end

         S_RESULT: begin
            if (ctl.ack) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         node_total_ff     <= '0;
         workload_total_ff <= '0;
         leader_ff         <= 1'b0;
         epoch_ff          <= EPOCH_RESET;
         rep_left_ff       <= '0;
         issue_ff          <= '0;
         pend_ff           <= 1'b0;
         found_ff          <= 1'b0;
      end else begin
         state_ff          <= state_in;
         node_total_ff     <= node_total_in;
         workload_total_ff <= workload_total_in;
         leader_ff         <= leader_in;
         epoch_ff          <= epoch_in;
         rep_left_ff       <= rep_left_in;
         issue_ff          <= issue_in;
         pend_ff           <= pend_in;
         found_ff          <= found_in;
      end
      pend_idx_ff  <= pend_idx_in;
      best_idx_ff  <= best_idx_in;
      best_load_ff <= best_load_in;
      tgt_idx_ff   <= tgt_idx_in;
      status_ff    <= status_in;
      assigned_ff  <= assigned_in;
      running_ff   <= running_in;
      placed_ff    <= placed_in;
   end

   // status and result
   assign stat.idle = (state_ff == S_IDLE);
   assign stat.done = (state_ff == S_RESULT);

   assign rsp.status        = status_ff;
   assign rsp.assigned_id   = assigned_ff;
   assign rsp.running_count = running_ff;
   assign rsp.placed_node   = placed_ff;
   assign rsp.leader_node   = LEADER_W'(leader_ff);
   assign rsp.epoch_value   = epoch_ff;

   // checks
   `LLD_ASSERT_ALWAYS(a_total_bound, clock, reset, node_total_ff <= NODE_MAX, "node count past table size")
   `LLD_ASSERT_IMPLY(a_scan_bound, clock, reset, state_ff == S_SCAN, issue_ff <= node_total_ff, "scan ran past node count")
   `LLD_ASSERT_NEXT(a_update_exit, clock, reset, state_ff == S_UPDATE, (state_ff == S_SCAN) || (state_ff == S_RESULT), "bad exit from placement")
   `LLD_ASSERT_NEXT(a_epoch_hold, clock, reset, !((state_ff == S_IDLE) && ctl.start && (req.op == OP_ELECT)), $stable(epoch_ff), "epoch moved without elect")

endmodule

`default_nettype wire

>>> src/least_loaded_node_dispatcher.sv
// least-loaded node dispatcher top level
//
// Requests arrive on req_bus (valid/ready); each carries op, target_node and
// replica_count. Every request gives exactly one beat on rsp_bus, in order.
// The node table (ready flag and 14-bit load per node) lives in a ram with a
// registered read; a sequencer walks it one entry per cycle.
// Register and elect go straight to the result; mark ready reads the entry
// and writes it back; schedule places R replicas over N registered nodes
// with one table scan plus one write back per replica.
// One request at a time: req_bus.ready is high while the sequencer is idle.
// The response sits in an output register: a new request is taken while a
// response still waits. If the receiver stalls, the next finished response is
// held in the sequencer until the output register empties.
// Reset is synchronous: node and workload counts go to zero, no leader, epoch
// one. No clearing pass is needed since entries are written when nodes join.
`timescale 1ns / 1ps
`default_nettype none

module least_loaded_node_dispatcher #(
   parameter int NODE_SLOTS     = lld_pkg::NODE_SLOTS_DEF,
   parameter int WORKLOAD_SLOTS = lld_pkg::WORKLOAD_SLOTS_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   lld_req_if.sink   req_bus,
   lld_rsp_if.source rsp_bus
);
   import lld_pkg::*;

   lld_ctl_type  core_ctl;
   lld_stat_type core_stat;
   lld_req_type  req_beat;
   lld_rsp_type  core_rsp;
   logic         out_free;
   logic         rsp_valid_ff, rsp_valid_in;
   lld_rsp_type  rsp_data_ff, rsp_data_in;

   // request beat
   assign req_beat.op            = req_bus.op;
   assign req_beat.target_node   = req_bus.target_node;
   assign req_beat.replica_count = req_bus.replica_count;
   assign req_bus.ready          = core_stat.idle;

   // handshake to the engine
   assign out_free       = !rsp_valid_ff || rsp_bus.ready;
   assign core_ctl.start = req_bus.valid && core_stat.idle;
   assign core_ctl.ack   = core_stat.done && out_free;

   lld_core #(
      .NODE_SLOTS     (NODE_SLOTS),
      .WORKLOAD_SLOTS (WORKLOAD_SLOTS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .ctl   (core_ctl),
      .req   (req_beat),
      .stat  (core_stat),
      .rsp   (core_rsp)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (core_ctl.ack) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = core_rsp;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   // response beat
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = rsp_data_ff.status;
   assign rsp_bus.assigned_id   = rsp_data_ff.assigned_id;
   assign rsp_bus.running_count = rsp_data_ff.running_count;
   assign rsp_bus.placed_node   = rsp_data_ff.placed_node;
   assign rsp_bus.leader_node   = rsp_data_ff.leader_node;
   assign rsp_bus.epoch_value   = rsp_data_ff.epoch_value;

endmodule

`default_nettype wire
